// ===== rtl/assert_macros.svh =====
// Assertion macros for the RTL of the PID controller.
// No dependencies; the macros expand to nothing when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Concurrent check, switched off while reset is held.
`define PIDC_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("pidc assertion failed");
// Concurrent check that also holds during reset.
`define PIDC_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("pidc assertion failed");
`else
`define PIDC_ASSERT(lbl, clk, rst_n, prop)
`define PIDC_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ===== rtl/pidc_pkg.sv =====
// Package of the PID controller: widths, reset values, register indexes
// and the beat types passed between the pipeline stages. No dependencies.
`timescale 1ns / 1ps
package pidc_pkg;

    localparam int MEAS_W     = 32;
    localparam int GAIN_W     = 20;
    localparam int LIM_W      = 16;
    localparam int SUM_W      = 16;
    localparam int ERR_W      = MEAS_W + 1;
    localparam int DELTA_W    = ERR_W + 1;
    localparam int P_W        = GAIN_W + ERR_W;
    localparam int I_W        = GAIN_W + SUM_W;
    localparam int D_W        = GAIN_W + DELTA_W;
    localparam int ACC_W      = D_W + 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int OUT_W      = 16;

    localparam int DEF_GAIN_FRAC_BITS = 12;

    localparam logic signed [MEAS_W-1:0] SETPOINT_RST  = 32'sd60000;
    localparam logic signed [GAIN_W-1:0] PROP_GAIN_RST = 20'sd410;
    localparam logic signed [GAIN_W-1:0] INT_GAIN_RST  = 20'sd0;
    localparam logic signed [GAIN_W-1:0] DER_GAIN_RST  = 20'sd0;
    localparam logic signed [LIM_W-1:0]  UPPER_RST     = 16'sd250;
    localparam logic signed [LIM_W-1:0]  LOWER_RST     = -16'sd250;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SETPOINT    = 3'd0,
        REG_PROP_GAIN   = 3'd1,
        REG_INT_GAIN    = 3'd2,
        REG_DER_GAIN    = 3'd3,
        REG_UPPER_LIMIT = 3'd4,
        REG_LOWER_LIMIT = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic signed [MEAS_W-1:0] setpoint;
        logic signed [GAIN_W-1:0] prop_gain;
        logic signed [GAIN_W-1:0] integral_gain_scaled;
        logic signed [GAIN_W-1:0] deriv_gain_scaled;
        logic signed [LIM_W-1:0]  upper_limit;
        logic signed [LIM_W-1:0]  lower_limit;
    } t_cfg;

    typedef struct packed {
        logic signed [ERR_W-1:0]   err;
        logic signed [DELTA_W-1:0] delta;
        logic signed [SUM_W-1:0]   sum;
    } t_err_beat;

    typedef struct packed {
        logic signed [P_W-1:0] p_term;
        logic signed [I_W-1:0] i_term;
        logic signed [D_W-1:0] d_term;
    } t_prod_beat;

endpackage

// ===== rtl/pidc_in_if.sv =====
// Input channel of the PID controller: one measured position per beat.
// Depends on pidc_pkg.
`timescale 1ns / 1ps
interface pidc_in_if import pidc_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic signed [MEAS_W-1:0] measured;

    modport source (output valid, output measured, input ready);
    modport sink   (input valid, input measured, output ready);
endinterface

// ===== rtl/pidc_out_if.sv =====
// Result channel of the PID controller: control value, direction, magnitude.
// Depends on pidc_pkg.
`timescale 1ns / 1ps
interface pidc_out_if import pidc_pkg::*;;
    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] control_value;
    logic                    direction;
    logic [OUT_W-1:0]        magnitude;

    modport source (output valid, output control_value, output direction,
                    output magnitude, input ready);
    modport sink   (input valid, input control_value, input direction,
                    input magnitude, output ready);
endinterface

// ===== rtl/pidc_cfg_if.sv =====
// Register write channel of the PID controller: index and data per beat.
// Depends on pidc_pkg.
`timescale 1ns / 1ps
interface pidc_cfg_if import pidc_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/pid_with_clamped_integral_top.sv =====
// PID position controller with a clamped error sum: one result beat per
// measured-position beat. Takes one beat every cycle while the result
// channel does not stall. The error-sum and previous-error registers are
// updated once per beat in the front stage, with its output register. Each
// measurement gives error = setpoint - measured (33 bits); the error sum is
// the old sum plus the error, clamped to the lower and upper limit (the upper
// test wins when the limits cross). The control value is the sum of the
// proportional, integral and derivative products with signed Q8.12 gains,
// truncated toward zero and clamped the same way; direction is 1 when the
// value is at least zero, magnitude is its absolute value. Every stage has
// its own valid bit, so bubbles collapse and input beats are taken while a
// result waits at the output. Registers are written through the
// configuration channel, always ready; write them only while the pipeline
// is empty. Indexes above the last register are ignored.
// Depends on pidc_pkg, the channel interfaces and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module pid_with_clamped_integral_top import pidc_pkg::*; #(
    parameter int GAIN_FRAC_BITS = DEF_GAIN_FRAC_BITS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    pidc_in_if.sink    i_meas,
    pidc_cfg_if.sink   i_cfg,
    pidc_out_if.source o_res
);

    t_cfg             w_cfg;
    logic             w_err_v;
    logic             w_err_rdy;
    t_err_beat        w_err;
    logic             w_prod_v;
    logic             w_prod_rdy;
    t_prod_beat       w_prod;
    logic             w_lim_ordered;
    logic             w_cv_in_window;
    logic             w_cv_neg;
    logic [OUT_W-1:0] w_cv_abs;
    logic             w_mag_dir_ok;

    // register file: holds setpoint, gains and limits
    pidc_cfg_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (w_cfg)
    );

    // input register, error and error-sum update
    pidc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_meas  (i_meas),
        .o_valid (w_err_v),
        .i_ready (w_err_rdy),
        .o_beat  (w_err)
    );

    // one multiplier per term, registered
    pidc_mult u_mult (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_valid (w_err_v),
        .o_ready (w_err_rdy),
        .i_beat  (w_err),
        .o_valid (w_prod_v),
        .i_ready (w_prod_rdy),
        .o_beat  (w_prod)
    );

    // add terms, truncate, clamp and drive the result channel
    pidc_final #(
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_final (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_valid (w_prod_v),
        .o_ready (w_prod_rdy),
        .i_beat  (w_prod),
        .o_res   (o_res)
    );

    // observation terms for the checks below
    assign w_lim_ordered  = (w_cfg.lower_limit <= w_cfg.upper_limit);
    assign w_cv_in_window = (o_res.control_value >= w_cfg.lower_limit)
                         && (o_res.control_value <= w_cfg.upper_limit);
    assign w_cv_neg       = o_res.control_value[OUT_W-1];
    assign w_cv_abs       = w_cv_neg ? (~o_res.control_value + 1'b1)
                                     : o_res.control_value;
    assign w_mag_dir_ok   = (o_res.direction == !w_cv_neg)
                         && (o_res.magnitude == w_cv_abs);

    // with ordered limits a result never leaves the clamp window
    `PIDC_ASSERT(a_ctl_in_window, i_clk, i_rst_n, (o_res.valid && w_lim_ordered) |-> w_cv_in_window)

    // direction and magnitude agree with the signed control value
    `PIDC_ASSERT(a_mag_dir, i_clk, i_rst_n, o_res.valid |-> w_mag_dir_ok)

    // a stalled error beat between front and multiplier is held unchanged
    `PIDC_ASSERT(a_err_hold, i_clk, i_rst_n, (w_err_v && !w_err_rdy) |=> (w_err_v && $stable(w_err)))

endmodule

// ===== rtl/pidc_cfg_regs.sv =====
// Configuration register file of the PID controller.
// Depends on pidc_pkg and pidc_cfg_if.
`timescale 1ns / 1ps
module pidc_cfg_regs import pidc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    pidc_cfg_if.sink   i_cfg,
    output t_cfg       o_cfg
);

    t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.setpoint             <= SETPOINT_RST;
            r_cfg.prop_gain            <= PROP_GAIN_RST;
            r_cfg.integral_gain_scaled <= INT_GAIN_RST;
            r_cfg.deriv_gain_scaled    <= DER_GAIN_RST;
            r_cfg.upper_limit          <= UPPER_RST;
            r_cfg.lower_limit          <= LOWER_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_SETPOINT:    r_cfg.setpoint             <= i_cfg.data[MEAS_W-1:0];
                REG_PROP_GAIN:   r_cfg.prop_gain            <= i_cfg.data[GAIN_W-1:0];
                REG_INT_GAIN:    r_cfg.integral_gain_scaled <= i_cfg.data[GAIN_W-1:0];
                REG_DER_GAIN:    r_cfg.deriv_gain_scaled    <= i_cfg.data[GAIN_W-1:0];
                REG_UPPER_LIMIT: r_cfg.upper_limit          <= i_cfg.data[LIM_W-1:0];
                REG_LOWER_LIMIT: r_cfg.lower_limit          <= i_cfg.data[LIM_W-1:0];
                default: ;
            endcase
        end
    end

endmodule

// ===== rtl/pidc_front.sv =====
// Front end of the PID controller: input register, error, delta and the
// clamped error sum with its state. Depends on pidc_pkg and pidc_in_if.
`timescale 1ns / 1ps
module pidc_front import pidc_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    pidc_in_if.sink   i_meas,
    output logic      o_valid,
    input  logic      i_ready,
    output t_err_beat o_beat
);

    logic                      r_a_v;
    logic signed [MEAS_W-1:0]  r_meas;
    logic                      r_b_v;
    t_err_beat                 r_b;
    t_err_beat                 n_b;
    logic signed [SUM_W-1:0]   r_sum;
    logic signed [SUM_W-1:0]   n_sum;
    logic signed [ERR_W-1:0]   r_prev;

    logic                      w_b_ready;
    logic                      w_a_ready;
    logic                      w_b_load;
    logic signed [ERR_W-1:0]   w_err;
    logic signed [DELTA_W-1:0] w_sumx;
    logic signed [DELTA_W-1:0] w_up;
    logic signed [DELTA_W-1:0] w_lo;

    assign w_b_ready    = !r_b_v || i_ready;
    assign w_a_ready    = !r_a_v || w_b_ready;
    assign w_b_load     = r_a_v && w_b_ready;
    assign i_meas.ready = w_a_ready;
    assign o_valid      = r_b_v;
    assign o_beat       = r_b;

    assign w_err  = ERR_W'(i_cfg.setpoint) - ERR_W'(r_meas);
    assign w_sumx = DELTA_W'(r_sum) + DELTA_W'(w_err);
    assign w_up   = DELTA_W'(i_cfg.upper_limit);
    assign w_lo   = DELTA_W'(i_cfg.lower_limit);

    // upper test first: with crossed limits the result is still a limit
    always_comb begin
        if (w_sumx >= w_up) begin
            n_sum = i_cfg.upper_limit;
        end else if (w_sumx <= w_lo) begin
            n_sum = i_cfg.lower_limit;
        end else begin
            n_sum = w_sumx[SUM_W-1:0];
        end
        n_b.err   = w_err;
        n_b.delta = DELTA_W'(w_err) - DELTA_W'(r_prev);
        n_b.sum   = n_sum;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v  <= 1'b0;
            r_b_v  <= 1'b0;
            r_sum  <= '0;
            r_prev <= '0;
        end else begin
            if (w_a_ready) r_a_v <= i_meas.valid;
            if (w_b_ready) r_b_v <= r_a_v;
            if (w_b_load) begin
                r_sum  <= n_sum;
                r_prev <= w_err;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_meas.valid && w_a_ready) r_meas <= i_meas.measured;
        if (w_b_load) r_b <= n_b;
    end

endmodule

// ===== rtl/pidc_mult.sv =====
// Multiplier stage of the PID controller: the three gain products.
// Depends on pidc_pkg.
`timescale 1ns / 1ps
module pidc_mult import pidc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_valid,
    output logic       o_ready,
    input  t_err_beat  i_beat,
    output logic       o_valid,
    input  logic       i_ready,
    output t_prod_beat o_beat
);

    logic       r_v;
    t_prod_beat r_beat;
    t_prod_beat n_beat;
    logic       w_ready;

    assign w_ready = !r_v || i_ready;
    assign o_ready = w_ready;
    assign o_valid = r_v;
    assign o_beat  = r_beat;

    always_comb begin
        n_beat.p_term = P_W'(i_cfg.prop_gain) * P_W'(i_beat.err);
        n_beat.i_term = I_W'(i_cfg.integral_gain_scaled) * I_W'(i_beat.sum);
        n_beat.d_term = D_W'(i_cfg.deriv_gain_scaled) * D_W'(i_beat.delta);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (w_ready) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && w_ready) r_beat <= n_beat;
    end

endmodule

// ===== rtl/pidc_final.sv =====
// Back end of the PID controller: sum of terms, truncation toward zero,
// output clamp and result register. Depends on pidc_pkg and pidc_out_if.
`timescale 1ns / 1ps
module pidc_final import pidc_pkg::*; #(
    parameter int GAIN_FRAC_BITS = DEF_GAIN_FRAC_BITS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_valid,
    output logic       o_ready,
    input  t_prod_beat i_beat,
    pidc_out_if.source o_res
);

    localparam int CTL_W = ACC_W - GAIN_FRAC_BITS;

    logic                    r_acc_v;
    logic signed [ACC_W-1:0] r_acc;
    logic                    r_out_v;
    logic signed [OUT_W-1:0] r_cv;
    logic                    r_dir;
    logic [OUT_W-1:0]        r_mag;
    logic signed [OUT_W-1:0] n_cv;

    logic                    w_out_ready;
    logic                    w_acc_ready;
    logic                    w_out_load;
    logic signed [ACC_W-1:0] w_sum;
    logic signed [ACC_W-1:0] w_biased;
    logic signed [CTL_W-1:0] w_ctl;
    logic signed [CTL_W-1:0] w_up;
    logic signed [CTL_W-1:0] w_lo;

    assign w_out_ready = !r_out_v || o_res.ready;
    assign w_acc_ready = !r_acc_v || w_out_ready;
    assign w_out_load  = r_acc_v && w_out_ready;
    assign o_ready     = w_acc_ready;

    assign w_sum = ACC_W'(i_beat.p_term) + ACC_W'(i_beat.i_term)
                 + ACC_W'(i_beat.d_term);

    // bias negatives by all-ones fraction so the shift rounds toward zero
    assign w_biased = r_acc + $signed({{(ACC_W-GAIN_FRAC_BITS){1'b0}},
                                       {GAIN_FRAC_BITS{r_acc[ACC_W-1]}}});
    assign w_ctl    = w_biased[ACC_W-1:GAIN_FRAC_BITS];
    assign w_up     = CTL_W'(i_cfg.upper_limit);
    assign w_lo     = CTL_W'(i_cfg.lower_limit);

    always_comb begin
        if (w_ctl >= w_up) begin
            n_cv = i_cfg.upper_limit;
        end else if (w_ctl <= w_lo) begin
            n_cv = i_cfg.lower_limit;
        end else begin
            n_cv = w_ctl[OUT_W-1:0];
        end
    end

    assign o_res.valid         = r_out_v;
    assign o_res.control_value = r_cv;
    assign o_res.direction     = r_dir;
    assign o_res.magnitude     = r_mag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_v <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (w_acc_ready) r_acc_v <= i_valid;
            if (w_out_ready) r_out_v <= r_acc_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && w_acc_ready) r_acc <= w_sum;
        if (w_out_load) begin
            r_cv  <= n_cv;
            r_dir <= !n_cv[OUT_W-1];
            r_mag <= n_cv[OUT_W-1] ? (~n_cv + 1'b1) : n_cv;
        end
    end

endmodule

// ===== sim/tb_top.sv =====
// Self-checking bench for the PID position controller with clamped error sum.
// Depends on pidc_pkg, the three channel interfaces and the controller RTL;
// predicts every control beat and compares it with what the block returns.
`timescale 1ns / 1ps
module tb_top import pidc_pkg::*; ;

    localparam int FRAC_BITS    = DEF_GAIN_FRAC_BITS;
    localparam int DRAIN_CYCLES = 12;
    localparam int LIMIT_CYCLES = 400000;

    // Indexes past the last register: the block must ignore writes to them.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

    typedef struct packed {
        logic signed [OUT_W-1:0] control_value;
        logic                    direction;
        logic [OUT_W-1:0]        magnitude;
    } t_control_beat;

    // Mirror of the controller: registers, error sum, previous error, and the
    // control beats still owed by the block, oldest first.
    class control_tracker;
        longint        setpoint;
        longint        kp;
        longint        ki;
        longint        kd;
        longint        upper;
        longint        lower;
        longint        error_sum;
        longint        prev_error;
        t_control_beat expected_controls[$];
        int            mismatches;

        function new();
            setpoint   = longint'(SETPOINT_RST);
            kp         = longint'(PROP_GAIN_RST);
            ki         = longint'(INT_GAIN_RST);
            kd         = longint'(DER_GAIN_RST);
            upper      = longint'(UPPER_RST);
            lower      = longint'(LOWER_RST);
            error_sum  = 0;
            prev_error = 0;
            mismatches = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_SETPOINT:    setpoint = longint'($signed(data));
                REG_PROP_GAIN:   kp       = longint'($signed(data[GAIN_W-1:0]));
                REG_INT_GAIN:    ki       = longint'($signed(data[GAIN_W-1:0]));
                REG_DER_GAIN:    kd       = longint'($signed(data[GAIN_W-1:0]));
                REG_UPPER_LIMIT: upper    = longint'($signed(data[LIM_W-1:0]));
                REG_LOWER_LIMIT: lower    = longint'($signed(data[LIM_W-1:0]));
                default: ;
            endcase
        endfunction

        // Upper test first, so crossed limits always land on one of them.
        function longint clamp_to_limits(longint x);
            if (x >= upper) return upper;
            if (x <= lower) return lower;
            return x;
        endfunction

        function void note_sample(logic signed [MEAS_W-1:0] meas);
            longint        m;
            longint        err;
            longint        acc;
            longint        ctl;
            t_control_beat beat;
            m         = longint'(meas);
            err       = setpoint - m;
            error_sum = clamp_to_limits(error_sum + err);
            acc       = kp * err + ki * error_sum + kd * (err - prev_error);
            // Drop the fraction bits, truncating toward zero.
            if (acc < 0) ctl = -((-acc) >>> FRAC_BITS);
            else ctl = acc >>> FRAC_BITS;
            ctl        = clamp_to_limits(ctl);
            prev_error = err;
            beat.control_value = ctl[OUT_W-1:0];
            beat.direction     = (ctl >= 0);
            beat.magnitude     = (ctl < 0) ? OUT_W'(-ctl) : OUT_W'(ctl);
            expected_controls.push_back(beat);
        endfunction

        function void note_mismatch(string what);
            mismatches++;
            if (mismatches <= 10) $display("mismatch: %s", what);
        endfunction

        function void check_control(logic signed [OUT_W-1:0] cv, logic dir,
                                    logic [OUT_W-1:0] mag);
            t_control_beat want;
            if (expected_controls.size() == 0) begin
                note_mismatch($sformatf("unexpected beat cv=%0d dir=%0b mag=%0d",
                                        cv, dir, mag));
                return;
            end
            want = expected_controls.pop_front();
            if (want.control_value !== cv || want.direction !== dir ||
                want.magnitude !== mag)
                note_mismatch($sformatf("expected cv=%0d dir=%0b mag=%0d, got cv=%0d dir=%0b mag=%0d",
                                        want.control_value, want.direction, want.magnitude,
                                        cv, dir, mag));
        endfunction

        function int pending();
            return expected_controls.size();
        endfunction
    endclass

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    pidc_in_if  meas_if ();
    pidc_cfg_if cfg_if ();
    pidc_out_if res_if ();

    control_tracker          tracker;
    logic                    res_ready = 1'b0;
    int                      ready_left = 0;
    int                      cycle_count = 0;
    bit                      quiet = 1'b0;
    logic signed [MEAS_W-1:0] target_pos = SETPOINT_RST;

    assign res_if.ready = res_ready;

    pid_with_clamped_integral_top #(
        .GAIN_FRAC_BITS(FRAC_BITS)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_meas (meas_if),
        .i_cfg  (cfg_if),
        .o_res  (res_if)
    );

    always #5 i_clk = ~i_clk;

    // Hard stop: far beyond the slowest correct run, even with every gap
    // and every stall at full length.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("tb_top: errors");
            $finish;
        end
    end

    // Gap length for either side: mostly none, some short, a few long.
    // Quiet phases run flat out.
    function automatic int pick_gap();
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Result side: check every accepted beat against the oldest prediction,
    // then decide the ready pattern for the next cycles. All values read here
    // are the ones held before this edge.
    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_ready)
            tracker.check_control(res_if.control_value, res_if.direction,
                                  res_if.magnitude);
        if (quiet) begin
            res_ready  <= 1'b1;
            ready_left = 0;
        end else if (ready_left > 0) begin
            ready_left--;
        end else if (res_ready) begin
            res_ready  <= 1'b0;
            ready_left = pick_gap();
        end else begin
            res_ready  <= 1'b1;
            ready_left = $urandom_range(0, 12);
        end
    end

    // Offer one measurement beat, after an optional gap; valid stays high
    // into the next beat when no gap follows.
    task automatic send_sample(input logic signed [MEAS_W-1:0] m);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            meas_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        meas_if.valid    <= 1'b1;
        meas_if.measured <= m;
        do @(posedge i_clk); while (!meas_if.ready);
        tracker.note_sample(m);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= data;
        do @(posedge i_clk); while (!cfg_if.ready);
        tracker.write_reg(idx, data);
    endtask

    // Keep the low bits of a narrow register value, fill the unused upper
    // bits of the data word with noise.
    function automatic logic [CFG_DATA_W-1:0] padded(logic [CFG_DATA_W-1:0] val, int w);
        logic [CFG_DATA_W-1:0] keep;
        keep = (w >= CFG_DATA_W) ? '1 : ((CFG_DATA_W'(1) << w) - 1);
        return ($urandom() & ~keep) | (val & keep);
    endfunction

    task automatic load_config(input logic [5:0] mask,
                               input logic signed [MEAS_W-1:0] sp,
                               input logic signed [GAIN_W-1:0] kp,
                               input logic signed [GAIN_W-1:0] ki,
                               input logic signed [GAIN_W-1:0] kd,
                               input logic signed [LIM_W-1:0]  up,
                               input logic signed [LIM_W-1:0]  lo);
        if (mask[REG_SETPOINT]) begin
            write_reg(REG_SETPOINT, sp);
            target_pos = sp;
        end
        if (mask[REG_PROP_GAIN])
            write_reg(REG_PROP_GAIN, padded(CFG_DATA_W'(kp), GAIN_W));
        if (mask[REG_INT_GAIN])
            write_reg(REG_INT_GAIN, padded(CFG_DATA_W'(ki), GAIN_W));
        if (mask[REG_DER_GAIN])
            write_reg(REG_DER_GAIN, padded(CFG_DATA_W'(kd), GAIN_W));
        if (mask[REG_UPPER_LIMIT])
            write_reg(REG_UPPER_LIMIT, padded(CFG_DATA_W'(up), LIM_W));
        if (mask[REG_LOWER_LIMIT])
            write_reg(REG_LOWER_LIMIT, padded(CFG_DATA_W'(lo), LIM_W));
        cfg_if.valid <= 1'b0;
    endtask

    // Wait for every owed beat, then give the pipeline time to empty.
    task automatic settle();
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic finish_phase();
        meas_if.valid <= 1'b0;
        settle();
    endtask

    function automatic logic signed [GAIN_W-1:0] rand_gain();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return GAIN_W'(int'($urandom_range(0, 16383)) - 8192);
        if (r < 75) return GAIN_W'($urandom());
        if (r < 85) return 20'sh7FFFF;
        if (r < 95) return 20'sh80000;
        return '0;
    endfunction

    function automatic logic signed [MEAS_W-1:0] rand_setpoint();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return int'($urandom_range(0, 200000)) - 100000;
        if (r < 85) return $urandom();
        if (r < 90) return 32'sh7FFFFFFF;
        if (r < 95) return 32'sh80000000;
        return '0;
    endfunction

    // Mostly near the target so the sum and the output move inside the
    // limits; the rest far off, random or at the extremes.
    function automatic logic signed [MEAS_W-1:0] rand_measured();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return target_pos + (int'($urandom_range(0, 400)) - 200);
        if (r < 80) return target_pos + (int'($urandom_range(0, 40000)) - 20000);
        if (r < 92) return $urandom();
        if (r < 95) return 32'sh7FFFFFFF;
        if (r < 98) return 32'sh80000000;
        return target_pos;
    endfunction

    initial begin
        logic [5:0]              mask;
        logic signed [LIM_W-1:0] up;
        logic signed [LIM_W-1:0] lo;
        int                      r;
        int                      n;

        tracker = new();
        meas_if.valid    <= 1'b0;
        meas_if.measured <= '0;
        cfg_if.valid     <= 1'b0;
        cfg_if.index     <= '0;
        cfg_if.data      <= '0;
        i_rst_n          <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: zero error, full-scale errors both ways, and small
        // negative errors where truncation toward zero matters.
        send_sample(32'sd60000);
        send_sample(32'sd0);
        send_sample(32'sh7FFFFFFF);
        send_sample(32'sh80000000);
        send_sample(32'sd60001);
        send_sample(32'sd60011);
        finish_phase();

        // Every register at an extreme, plus writes to the unused indexes.
        write_reg(REG_SPARE_A, $urandom());
        write_reg(REG_SPARE_B, $urandom());
        load_config(6'h3F, 32'sh80000000, 20'sh7FFFF, 20'sh80000, 20'sh7FFFF,
                    16'sh7FFF, 16'sh8000);
        send_sample(32'sh7FFFFFFF);
        send_sample(32'sh80000000);
        send_sample(32'sd0);
        send_sample($urandom());
        send_sample($urandom());
        finish_phase();

        // Crossed limits: every value must land on one of the two.
        load_config(6'h3F, 32'sd0, 20'sd4096, 20'sd0, 20'sd0, -16'sd100, 16'sd100);
        send_sample(-32'sd50);
        send_sample(32'sd500);
        send_sample(32'sd0);
        finish_phase();
        // Equal limits.
        load_config(6'b110000, '0, '0, '0, '0, 16'sd7, 16'sd7);
        send_sample(32'sd3);
        finish_phase();

        // Unit gain: values exactly at and just inside each limit.
        load_config(6'h3F, 32'sd0, 20'sd4096, 20'sd0, 20'sd0, 16'sd100, -16'sd100);
        send_sample(-32'sd100);
        send_sample(32'sd100);
        send_sample(-32'sd99);
        send_sample(32'sd99);
        send_sample(32'sd0);
        finish_phase();

        // Widest limits, output pinned to the most negative and most positive.
        load_config(6'h3F, 32'sd0, 20'sh7FFFF, 20'sd0, 20'sd0, 16'sh7FFF, 16'sh8000);
        send_sample(32'sh7FFFFFFF);
        send_sample(32'sh80000000);
        finish_phase();

        // Random phases rewriting most registers, two of them without gaps.
        for (int ph = 0; ph < 10; ph++) begin
            quiet = (ph == 3 || ph == 7);
            mask  = '1;
            if (ph > 0)
                for (int b = 0; b < 6; b++) mask[b] = ($urandom_range(0, 9) < 8);
            r = $urandom_range(0, 99);
            if (r < 60) begin
                up = LIM_W'($urandom_range(1, 32767));
                lo = LIM_W'(-int'($urandom_range(1, 32768)));
            end else if (r < 75) begin
                up = LIM_W'(-int'($urandom_range(0, 2000)));
                lo = LIM_W'($urandom_range(0, 2000));
            end else if (r < 85) begin
                up = 16'sh7FFF;
                lo = 16'sh8000;
            end else begin
                up = LIM_W'($urandom());
                lo = LIM_W'($urandom());
            end
            if ($urandom_range(0, 9) == 0)
                write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, $urandom());
            load_config(mask, rand_setpoint(), rand_gain(), rand_gain(), rand_gain(),
                        up, lo);
            n = $urandom_range(55, 85);
            repeat (n) send_sample(rand_measured());
            finish_phase();
        end

        if (tracker.mismatches == 0 && tracker.pending() == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
